FILE: src/wtss_pkg.sv
// Package for the weighted triangle series sum block.
// Holds the fixed-point widths, register codes, config struct, sequencer states
// and the triangle wave function. It depends on nothing else.
package wtss_pkg;

    // Fixed-point formats: points are Q0.F, weights and triangles are Q1.F
    localparam int FRAC_BITS = 32;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * Q_W;
    localparam int SUM_W     = 41;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = Q_W;

    localparam logic [Q_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Register reset values
    localparam logic [Q_W-1:0]       RST_WEIGHT     = Q_W'(64'h8000_0000);
    localparam logic [FRAC_BITS-1:0] RST_MIN_WEIGHT = FRAC_BITS'(1);
    localparam logic [CNT_W-1:0]     RST_TERM_LIMIT = CNT_W'(350);

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT     = 2'd0,
        CFG_MIN_WEIGHT = 2'd1,
        CFG_TERM_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [Q_W-1:0]       weight;
        logic [FRAC_BITS-1:0] min_weight;
        logic [CNT_W-1:0]     term_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TERM,
        ST_WGT,
        ST_FINISH
    } t_state;

    // Triangle of a fraction t: 2t below one half, 2(1 - t) otherwise, Q1.F
    function automatic logic [Q_W-1:0] tri_wave(input logic [FRAC_BITS-1:0] t);
        logic [FRAC_BITS-1:0] folded;
        folded = t[FRAC_BITS-1] ? (FRAC_BITS'(0) - t) : t;
        return {folded, 1'b0};
    endfunction

endpackage

FILE: src/wtss_mul.sv
// Shared multiplier of the weighted triangle series sum block.
// One Q1.F by Q1.F product per cycle, registered. Uses wtss_pkg.
module wtss_mul (
    input  logic                      i_clk,
    input  logic [wtss_pkg::Q_W-1:0]    i_a,
    input  logic [wtss_pkg::Q_W-1:0]    i_b,
    output logic [wtss_pkg::PROD_W-1:0] o_prod
);
    import wtss_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Register the full product
    always_ff @(posedge i_clk) begin
        r_prod <= {{Q_W{1'b0}}, i_a} * {{Q_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

FILE: src/wtss_seq.sv
// Sequencer and datapath of the weighted triangle series sum block.
// Steps one point through the series on the shared multiplier and holds the
// result beat. Uses wtss_pkg and drives wtss_mul through its operand ports.
module wtss_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wtss_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [wtss_pkg::FRAC_BITS-1:0] i_point,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [wtss_pkg::SUM_W-1:0]     o_series_sum,
    output logic [wtss_pkg::CNT_W-1:0]     o_terms_used,
    output logic [wtss_pkg::Q_W-1:0]       o_mul_a,
    output logic [wtss_pkg::Q_W-1:0]       o_mul_b,
    input  logic [wtss_pkg::PROD_W-1:0]    i_mul_prod
);
    import wtss_pkg::*;

    t_state               r_state, n_state;
    logic                 r_wvalid, n_wvalid;
    logic                 r_out_valid, n_out_valid;
    logic [FRAC_BITS-1:0] r_x, n_x;
    logic [FRAC_BITS-1:0] r_t, n_t;
    logic [Q_W-1:0]       r_tw, n_tw;
    logic [Q_W-1:0]       r_w, n_w;
    logic [FRAC_BITS-1:0] r_minw, n_minw;
    logic [CNT_W-1:0]     r_limit, n_limit;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_acc, n_acc;
    logic [SUM_W-1:0]     r_out_sum, n_out_sum;
    logic [CNT_W-1:0]     r_out_cnt, n_out_cnt;

    logic [Q_W-1:0] prod_hi;
    logic [Q_W-1:0] tw_cur;
    logic           stop;
    logic           out_free;

    // Product scaled back to Q1.F; values never exceed 1.0
    assign prod_hi  = i_mul_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
    assign tw_cur   = r_wvalid ? prod_hi : r_tw;
    assign stop     = r_wvalid && ((r_cnt == r_limit) || (tw_cur < {1'b0, r_minw}));
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state, datapath updates and multiplier operands
    always_comb begin
        n_state     = r_state;
        n_wvalid    = r_wvalid;
        n_out_valid = r_out_valid && i_out_stall;
        n_x         = r_x;
        n_t         = r_t;
        n_tw        = r_tw;
        n_w         = r_w;
        n_minw      = r_minw;
        n_limit     = r_limit;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_out_sum   = r_out_sum;
        n_out_cnt   = r_out_cnt;
        o_mul_a     = r_tw;
        o_mul_b     = tri_wave(r_t);
        o_in_stall  = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_x      = i_point;
                    n_t      = i_point;
                    n_tw     = ONE;
                    n_w      = (i_cfg.weight > ONE) ? ONE : i_cfg.weight;
                    n_minw   = i_cfg.min_weight;
                    n_limit  = (i_cfg.term_limit == '0) ? CNT_W'(1) : i_cfg.term_limit;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_wvalid = 1'b0;
                    n_state  = ST_TERM;
                end
            end
            // Take the new weight, stop or multiply it by the triangle
            ST_TERM: begin
                n_tw    = tw_cur;
                o_mul_a = tw_cur;
                o_mul_b = tri_wave(r_t);
                n_state = stop ? ST_FINISH : ST_WGT;
            end
            // Add the term, advance the harmonic, multiply the weight by w
            ST_WGT: begin
                n_acc    = r_acc + {{(SUM_W-Q_W){1'b0}}, prod_hi};
                n_cnt    = r_cnt + CNT_W'(1);
                n_t      = r_t + r_x;
                n_wvalid = 1'b1;
                o_mul_a  = r_tw;
                o_mul_b  = r_w;
                n_state  = ST_TERM;
            end
            // Hand the result to the output register once it is free
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_acc;
                    n_out_cnt   = r_cnt;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wvalid    <= n_wvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_t       <= n_t;
        r_tw      <= n_tw;
        r_w       <= n_w;
        r_minw    <= n_minw;
        r_limit   <= n_limit;
        r_cnt     <= n_cnt;
        r_acc     <= n_acc;
        r_out_sum <= n_out_sum;
        r_out_cnt <= n_out_cnt;
    end

    assign o_out_valid  = r_out_valid;
    assign o_series_sum = r_out_sum;
    assign o_terms_used = r_out_cnt;

endmodule

FILE: src/weighted_triangle_series_sum.sv
// Top level of the weighted triangle series sum block.
// Holds the config registers and joins wtss_seq to wtss_mul. Uses wtss_pkg.
//
// For a point x in [0,1) (unsigned Q0.32) the block sums w^k * tri((k+1)x)
// over k, with every product truncated, and returns the Q9.32 sum and the
// number of terms added. Summing stops after term_limit terms (zero counts as
// one) or right after the running weight drops below min_weight; w above 1.0
// is clamped to 1.0. One multiplier is shared by the term product and the
// weight update, which take turns on it for each term. With the default weight
// and floor a point adds 33 terms; the default limit is 350 terms. The input
// stalls while a point is in work; a finished result sits in an output
// register, so the next point is taken while it waits. Write the config
// registers only while the block is idle; the write port is always ready.
module weighted_triangle_series_sum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wtss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wtss_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [wtss_pkg::FRAC_BITS-1:0] i_point,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [wtss_pkg::SUM_W-1:0]     o_series_sum,
    output logic [wtss_pkg::CNT_W-1:0]     o_terms_used
);
    import wtss_pkg::*;

    t_cfg              r_cfg;
    logic [Q_W-1:0]    mul_a;
    logic [Q_W-1:0]    mul_b;
    logic [PROD_W-1:0] mul_prod;

    assign o_cfg_ready = 1'b1;

    // Write config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight     <= RST_WEIGHT;
            r_cfg.min_weight <= RST_MIN_WEIGHT;
            r_cfg.term_limit <= RST_TERM_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WEIGHT:     r_cfg.weight     <= i_cfg_data;
                CFG_MIN_WEIGHT: r_cfg.min_weight <= i_cfg_data[FRAC_BITS-1:0];
                CFG_TERM_LIMIT: r_cfg.term_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    wtss_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_point      (i_point),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_series_sum (o_series_sum),
        .o_terms_used (o_terms_used),
        .o_mul_a      (mul_a),
        .o_mul_b      (mul_b),
        .i_mul_prod   (mul_prod)
    );

    wtss_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

endmodule

FILE: src/wtss_checker.sv
// Port checker for the weighted triangle series sum block, with its bind.
// Watches only the top level's ports. Uses wtss_pkg for widths.
module wtss_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [wtss_pkg::SUM_W-1:0]     o_series_sum,
    input logic [wtss_pkg::CNT_W-1:0]     o_terms_used
);
    import wtss_pkg::*;

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // Block keeps the input stalled after it takes a point, through the first term
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_in_stall ##1 o_in_stall)
        else $error("input taken while previous point still in work");

    // A new result cannot appear right after a point is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !$rose(o_out_valid))
        else $error("result appeared without computing");

    // Every result counts at least one term
    a_terms_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_terms_used != '0))
        else $error("result with zero terms");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_series_sum) && $stable(o_terms_used)))
        else $error("stalled result changed");

endmodule

bind weighted_triangle_series_sum wtss_checker u_wtss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_series_sum (o_series_sum),
    .o_terms_used (o_terms_used)
);

FILE: test/weighted_triangle_series_sum_tb.sv
// Testbench for weighted_triangle_series_sum: directed stimulus table, then random phases.
// Each result beat is checked against a table value or an in-bench triangle series model.
// Depends on wtss_pkg and the weighted_triangle_series_sum RTL.
`timescale 1ns / 100ps

module weighted_triangle_series_sum_tb;
    import wtss_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 2500;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_MIXES = 11;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] terms;
    } t_series;

    typedef enum bit [0:0] {
        ROW_CFG,
        ROW_POINT
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [Q_W-1:0]       weight;
        logic [FRAC_BITS-1:0] min_w;
        logic [CNT_W-1:0]     limit;
        logic [FRAC_BITS-1:0] point;
        bit                   typed;
        t_series              result;
    } t_step;

    // Register settings used by the random phases
    typedef enum int {
        MIX_RESET,
        MIX_WIDE,
        MIX_SLOW_DECAY,
        MIX_SMALL_FLOOR,
        MIX_CLAMPED,
        MIX_FULL_LENGTH
    } t_mix;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WEIGHT;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic [FRAC_BITS-1:0] i_point     = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [SUM_W-1:0]     o_series_sum;
    logic [CNT_W-1:0]     o_terms_used;

    // Register copies that the model works from
    logic [Q_W-1:0]       set_weight = RST_WEIGHT;
    logic [FRAC_BITS-1:0] set_min_w  = RST_MIN_WEIGHT;
    logic [CNT_W-1:0]     set_limit  = RST_TERM_LIMIT;

    t_series sums_due[$];
    t_step   steps[$];
    t_series got_beat;
    t_series want_beat;
    int      mismatches = 0;
    int      cycles     = 0;
    int      burst_left = 0;
    bit      hold_req   = 1'b0;
    bit      hold_taken = 1'b0;
    int      hold_left  = 0;
    int      rx_cycle   = 0;
    int      stall_mode = 0;

    t_mix plan [RANDOM_MIXES] = '{MIX_RESET, MIX_WIDE, MIX_SLOW_DECAY, MIX_SMALL_FLOOR,
                                  MIX_CLAMPED, MIX_FULL_LENGTH, MIX_WIDE, MIX_SLOW_DECAY,
                                  MIX_SMALL_FLOOR, MIX_CLAMPED, MIX_RESET};

    weighted_triangle_series_sum dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_point      (i_point),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_series_sum (o_series_sum),
        .o_terms_used (o_terms_used)
    );

    always #6 i_clk = ~i_clk;

    // Sum w^k * tri((k+1)x) with truncated products, stopping on limit or weight floor
    function automatic t_series triangle_series(input logic [FRAC_BITS-1:0] x);
        logic [Q_W-1:0]       decay;
        logic [Q_W-1:0]       run_w;
        logic [Q_W-1:0]       ramp;
        logic [FRAC_BITS-1:0] frac;
        logic [2*Q_W-1:0]     prod;
        logic [63:0]          acc;
        logic [CNT_W-1:0]     lim;
        logic [CNT_W-1:0]     used;
        bit                   stop;
        int                   k;
        t_series              r;
        decay = (set_weight > ONE) ? ONE : set_weight;
        lim   = (set_limit == '0) ? CNT_W'(1) : set_limit;
        run_w = ONE;
        acc   = '0;
        used  = '0;
        stop  = 1'b0;
        for (k = 0; k < lim && !stop; k++) begin
            frac = x * 32'(k + 1);
            ramp = frac[FRAC_BITS-1] ? (ONE - {1'b0, frac}) << 1 : {1'b0, frac} << 1;
            prod = run_w * ramp;
            acc  = acc + 64'(prod[2*Q_W-1:FRAC_BITS]);
            used = CNT_W'(k + 1);
            prod = run_w * decay;
            run_w = prod[FRAC_BITS+Q_W-1:FRAC_BITS];
            if (run_w < {1'b0, set_min_w})
                stop = 1'b1;
        end
        r.sum   = (acc > 64'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        r.terms = used;
        return r;
    endfunction

    function automatic t_step cfg_row(input logic [Q_W-1:0] w, input logic [FRAC_BITS-1:0] mw,
                                      input logic [CNT_W-1:0] lim);
        t_step s;
        s        = '0;
        s.kind   = ROW_CFG;
        s.weight = w;
        s.min_w  = mw;
        s.limit  = lim;
        return s;
    endfunction

    function automatic t_step pt_row(input logic [FRAC_BITS-1:0] p);
        t_step s;
        s       = '0;
        s.kind  = ROW_POINT;
        s.point = p;
        return s;
    endfunction

    function automatic t_step pt_chk(input logic [FRAC_BITS-1:0] p, input logic [SUM_W-1:0] sum,
                                     input logic [CNT_W-1:0] terms);
        t_step s;
        s              = pt_row(p);
        s.typed        = 1'b1;
        s.result.sum   = sum;
        s.result.terms = terms;
        return s;
    endfunction

    // Points biased toward edges of the unit interval and dyadic fractions
    function automatic logic [FRAC_BITS-1:0] rand_point();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) == 0) ? 32'h0 :
                      (($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'h8000_0000);
            1: return 32'($urandom_range(0, 255));
            2: return 32'd1 << $urandom_range(0, 31);
            3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
            default: return 32'($urandom);
        endcase
    endfunction

    // Write one register; valid stays high so the caller can chain beats
    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WEIGHT:     set_weight = data[Q_W-1:0];
            CFG_MIN_WEIGHT: set_min_w  = data[FRAC_BITS-1:0];
            CFG_TERM_LIMIT: set_limit  = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] mw,
                                 input logic [CFG_DAT_W-1:0] lim);
        put_reg(CFG_WEIGHT, w);
        put_reg(CFG_MIN_WEIGHT, mw);
        put_reg(CFG_TERM_LIMIT, lim);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sums_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Offer one point; keep valid up while the burst has more beats, else drop it
    task automatic send_point(input logic [FRAC_BITS-1:0] p, input bit more, input bit typed,
                              input t_series typed_result);
        i_in_valid <= 1'b1;
        i_point    <= p;
        do @(posedge i_clk); while (o_in_stall);
        sums_due.push_back(typed ? typed_result : triangle_series(p));
        burst_left--;
        if (!more) begin
            i_in_valid <= 1'b0;
        end else if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    // Receiver stall pattern, with one long hold-off when asked
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 1) == 0);
                2: i_out_stall <= (rx_cycle % 16 < 12);
                default: i_out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Check each result beat against the oldest pending sum
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            got_beat.sum   = o_series_sum;
            got_beat.terms = o_terms_used;
            if (sums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: sum %h terms %0d",
                             got_beat.sum, got_beat.terms);
            end else begin
                want_beat = sums_due.pop_front();
                if (got_beat !== want_beat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: sum exp %h got %h, terms exp %0d got %0d",
                                 want_beat.sum, got_beat.sum, want_beat.terms, got_beat.terms);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("weighted_triangle_series_sum verification failed");
            $finish;
        end
    end

    initial begin
        int      i;
        int      j;
        int      ph;
        int      n;
        bit      more;
        t_mix    mix;
        logic [Q_W-1:0]       w;
        logic [FRAC_BITS-1:0] mw;
        logic [CNT_W-1:0]     lim;

        // Directed table: reset settings, limits, clamping, floors
        steps.push_back(pt_chk(32'h0, 41'h0, 9'd33));
        steps.push_back(pt_row(32'hFFFF_FFFF));
        steps.push_back(pt_row(32'h8000_0000));
        steps.push_back(pt_row(32'h0000_0001));
        steps.push_back(pt_row(32'h4000_0000));
        steps.push_back(cfg_row(33'h0_8000_0000, 32'd1, 9'd1));
        steps.push_back(pt_chk(32'h4000_0000, 41'h0_8000_0000, 9'd1));
        steps.push_back(pt_chk(32'h8000_0000, 41'h1_0000_0000, 9'd1));
        steps.push_back(pt_chk(32'h0, 41'h0, 9'd1));
        // zero term limit counts as one term
        steps.push_back(cfg_row(33'h0_8000_0000, 32'd1, 9'd0));
        steps.push_back(pt_chk(32'h8000_0000, 41'h1_0000_0000, 9'd1));
        steps.push_back(pt_row(32'hFFFF_FFFF));
        // weight above one clamps; zero floor runs the full limit
        steps.push_back(cfg_row(33'h1_FFFF_FFFF, 32'd0, 9'd511));
        steps.push_back(pt_chk(32'h8000_0000, 41'h100_0000_0000, 9'd511));
        steps.push_back(pt_chk(32'h0, 41'h0, 9'd511));
        steps.push_back(pt_row(32'hFFFF_FFFF));
        // zero weight stops after the first term
        steps.push_back(cfg_row(33'h0, 32'd1, 9'd350));
        steps.push_back(pt_chk(32'h4000_0000, 41'h0_8000_0000, 9'd1));
        steps.push_back(pt_row(32'hC000_0000));
        steps.push_back(cfg_row(33'h0_FFFF_FFFF, 32'hFFFF_FFFF, 9'd20));
        steps.push_back(pt_row(32'h5555_5555));
        steps.push_back(pt_row(32'hFFFF_FFFF));
        steps.push_back(cfg_row(33'h1_0000_0000, 32'hFFFF_FFFF, 9'd9));
        steps.push_back(pt_chk(32'h0, 41'h0, 9'd9));
        steps.push_back(pt_row(32'h2AAA_AAAB));
        steps.push_back(cfg_row(33'h1_0000_0001, 32'd0, 9'd256));
        steps.push_back(pt_chk(32'h8000_0000, 41'h080_0000_0000, 9'd256));
        steps.push_back(pt_row(32'h1234_5678));
        steps.push_back(cfg_row(33'h0_8000_0000, 32'd1, 9'd350));
        steps.push_back(pt_row(32'h7FFF_FFFF));
        steps.push_back(pt_row(32'h8000_0001));

        burst_left = $urandom_range(1, 8);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; settings change only once all sums are back
        for (i = 0; i < steps.size(); i++) begin
            if (steps[i].kind == ROW_CFG) begin
                drain();
                load_settings(steps[i].weight, {1'b0, steps[i].min_w},
                              CFG_DAT_W'(steps[i].limit));
            end else begin
                more = (i + 1 < steps.size()) && (steps[i+1].kind == ROW_POINT);
                send_point(steps[i].point, more, steps[i].typed, steps[i].result);
            end
        end

        // Random phases, one register setting each
        for (ph = 0; ph < RANDOM_MIXES; ph++) begin
            mix = plan[ph];
            n   = (mix == MIX_FULL_LENGTH) ? 4 : 43;
            case (mix)
                MIX_RESET: begin
                    w = RST_WEIGHT; mw = RST_MIN_WEIGHT; lim = RST_TERM_LIMIT;
                end
                MIX_WIDE: begin
                    w   = {1'($urandom_range(0, 1)), 32'($urandom)};
                    mw  = 32'($urandom);
                    lim = 9'($urandom_range(1, 64));
                end
                MIX_SLOW_DECAY: begin
                    w   = {1'b0, 32'hC000_0000 | 32'($urandom)};
                    mw  = 32'($urandom_range(0, 1 << 20));
                    lim = 9'($urandom_range(1, 48));
                end
                MIX_SMALL_FLOOR: begin
                    w   = {1'b0, 32'($urandom)};
                    mw  = 32'($urandom_range(0, 1));
                    lim = 9'($urandom_range(0, 40));
                end
                MIX_CLAMPED: begin
                    w   = {1'b1, 32'($urandom)};
                    mw  = '0;
                    lim = 9'($urandom_range(1, 30));
                end
                default: begin
                    w = ONE; mw = '0; lim = 9'd511;
                end
            endcase
            drain();
            // unused upper data bits carry junk
            load_settings(w, {1'($urandom_range(0, 1)), mw}, {24'($urandom), lim});
            if (mix == MIX_SLOW_DECAY)
                hold_req = 1'b1;
            for (j = 0; j < n; j++)
                send_point(rand_point(), j + 1 < n, 1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sums_due.size() == 0)
            $display("weighted_triangle_series_sum verification clean");
        else
            $display("weighted_triangle_series_sum verification failed");
        $finish;
    end

endmodule

FILE: weighted_triangle_series_sum.f
src/wtss_pkg.sv
src/wtss_mul.sv
src/wtss_seq.sv
src/weighted_triangle_series_sum.sv
src/wtss_checker.sv
test/weighted_triangle_series_sum_tb.sv
